// ===== src/dmp_pkg.sv =====
package dmp_pkg;

  localparam int unsigned PACKET_BYTES_DEF = 512;
  localparam int unsigned NAME_CHARS_DEF   = 255;

  localparam logic [3:0] MAX_ANSWERS_RST = 4'd3;
  localparam int unsigned HDR_BYTES      = 12;
  localparam logic [7:0] STEP_LIMIT      = 8'd255;
  localparam logic [1:0] LABEL_PTR       = 2'b11;
  localparam logic [7:0] DOT_CHAR        = 8'h2E;
  localparam logic [15:0] TYPE_A         = 16'd1;
  localparam logic [15:0] IPV4_LEN       = 16'd4;
  localparam logic [3:0] QUES_FIX_BYTES  = 4'd4;
  localparam logic [3:0] ANS_FIX_BYTES   = 4'd10;

  typedef enum logic [3:0] {
    K_HDR        = 4'd0,
    K_CHAR       = 4'd1,
    K_QUES       = 4'd2,
    K_ANS        = 4'd3,
    K_ESHORTHDR  = 4'd4,
    K_EBADNAME   = 4'd5,
    K_ESHORTQ    = 4'd6,
    K_ESHORTA    = 4'd7,
    K_ESHORTRD   = 4'd8,
    K_DONE       = 4'd9
  } kind_e;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    kind_e        kind;
    logic [15:0]  msg_id;
    logic [15:0]  flags_word;
    logic [15:0]  question_count;
    logic [15:0]  answer_count;
    logic [7:0]   name_char;
    logic [15:0]  rr_type;
    logic [15:0]  rr_class;
    logic [31:0]  ttl;
    logic [15:0]  rdata_len;
    logic [13:0]  rdata_offset;
    logic [31:0]  ipv4_addr;
  } out_req_t;

endpackage

// ===== src/dns_message_parser_core.sv =====
// DNS message parser. Load a message with func=0 requests (one byte each,
// last_byte on the final one); no result comes back for a load. Then each
// func=1 request after the load returns one parse item: the header, the
// question names one character at a time followed by a question item, then
// up to max_answers answers (name characters, then the answer item).
// Compression pointers are followed; malformed data ends the parse with an
// error item, and every later pull returns done. The message sits in a
// single-port-read RAM, so timing is set by its one read per cycle. A
// header, short-header or done item is registered straight from the
// request; a name character or dot is read through the name-walk states,
// and question and answer items also pass the fetch states for their fixed
// part and, for an answer with an IPv4 address, for that address. Label
// steps, pointer steps and labels skipped on a full name lengthen a pull.
// One request is in flight at a time and the next is accepted once the
// result has been taken.
module dns_message_parser_core import dmp_pkg::*; #(
  parameter int unsigned PACKET_BYTES = PACKET_BYTES_DEF,
  parameter int unsigned NAME_CHARS   = NAME_CHARS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_req_t    in_req_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_req_t   out_req_o
);

  localparam int unsigned AW = $clog2(PACKET_BYTES);
  localparam int unsigned OW = $clog2(PACKET_BYTES + 1);
  localparam int unsigned CW = 17;   // room for offset + 16-bit length

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_LOAD  = 6'b000010,
    PH_HDR   = 6'b000100,
    PH_QNAME = 6'b001000,
    PH_ANAME = 6'b010000,
    PH_DONE  = 6'b100000
  } phase_e;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,  // waiting for a request
    S_WALK = 10'b0000000010,  // name walk decision
    S_LAB  = 10'b0000000100,  // label/pointer byte back from RAM
    S_PTR  = 10'b0000001000,  // pointer low byte back
    S_CHR  = 10'b0000010000,  // label character back
    S_REC  = 10'b0000100000,  // name done, check fixed part fits
    S_FREQ = 10'b0001000000,  // fetch: issue read
    S_FDAT = 10'b0010000000,  // fetch: capture byte
    S_ACHK = 10'b0100000000,  // rdata length check
    S_FIN  = 10'b1000000000   // deliver question/answer item
  } state_e;

  state_e      st_q, st_d;
  phase_e      ph_q, ph_d;
  logic [OW-1:0] len_q, len_d, off_q, off_d, res_q, res_d, rdoff_q, rdoff_d;
  logic        pt_q, pt_d, fip_q, fip_d, ov_q, ov_d;
  logic [7:0]  step_q, step_d, chars_q, chars_d;
  logic [5:0]  lr_q, lr_d, plo_q, plo_d;
  logic [15:0] rec_q, rec_d;
  logic [3:0]  maxa_q, maxa_d, cnt_q, cnt_d;
  logic [63:0] hdr_q, hdr_d;
  logic [79:0] acc_q, acc_d;
  logic [31:0] ip_q, ip_d;
  out_req_t    out_q, out_d;

  logic          ram_we;
  logic [OW-1:0] wlen;
  logic [7:0]    rdata;
  logic          in_acc;
  logic          nb;        // start a name walk
  phase_e        nb_ph;
  logic          go_ans;    // enter the answer section
  logic [15:0]   rec_inc;
  logic [13:0]   ptr;

  wire [15:0] hdr_id = hdr_q[63:48];
  wire [15:0] hdr_fl = hdr_q[47:32];
  wire [15:0] hdr_qd = hdr_q[31:16];
  wire [15:0] hdr_an = hdr_q[15:0];

  assign in_stall_o  = (st_q != S_IDLE) | ov_q;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = ov_q;
  assign out_req_o   = out_q;
  assign wlen        = (ph_q != PH_LOAD) ? OW'(0) : len_q;
  assign rec_inc     = rec_q + 16'd1;
  assign ptr         = {plo_q, rdata};

  // The RAM is read at the current offset every cycle; states that need a
  // byte move the offset on and pick it up in the next state.
  dmp_ram #(.WIDTH(8), .DEPTH(PACKET_BYTES)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wlen[AW-1:0]),
    .wdata_i (in_req_i.data_byte),
    .raddr_i (off_q[AW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    st_d = st_q;  ph_d = ph_q;  len_d = len_q;  off_d = off_q;  res_d = res_q;
    rdoff_d = rdoff_q;  pt_d = pt_q;  fip_d = fip_q;  step_d = step_q;
    chars_d = chars_q;  lr_d = lr_q;  plo_d = plo_q;  rec_d = rec_q;
    maxa_d = maxa_q;  cnt_d = cnt_q;  hdr_d = hdr_q;  acc_d = acc_q;
    ip_d = ip_q;  out_d = out_q;  ov_d = ov_q;
    ram_we = 1'b0;  nb = 1'b0;  nb_ph = PH_QNAME;  go_ans = 1'b0;

    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end
    if (cfg_we_i) begin
      maxa_d = cfg_data_i;
    end

    case (st_q)
      S_IDLE: begin
        if (in_acc && !in_req_i.func) begin
          // load: a byte outside a load session starts a new message
          if (CW'(wlen) < CW'(PACKET_BYTES)) begin
            ram_we = 1'b1;
            len_d  = wlen + OW'(1);
          end else begin
            len_d = wlen;
          end
          if (CW'(wlen) < CW'(8)) begin
            hdr_d[63 - 8 * wlen[2:0] -: 8] = in_req_i.data_byte;
          end
          ph_d = in_req_i.last_byte ? PH_HDR : PH_LOAD;
        end else if (in_acc) begin
          out_d = '0;
          case (ph_q)
            PH_DONE: begin
              out_d.kind = K_DONE;
              ov_d = 1'b1;
            end
            PH_HDR: begin
              ov_d = 1'b1;
              if (CW'(len_q) < CW'(HDR_BYTES)) begin
                out_d.kind = K_ESHORTHDR;
                ph_d = PH_DONE;
              end else begin
                out_d.kind           = K_HDR;
                out_d.msg_id         = hdr_id;
                out_d.flags_word     = hdr_fl;
                out_d.question_count = hdr_qd;
                out_d.answer_count   = hdr_an;
                off_d = OW'(HDR_BYTES);
                rec_d = '0;
                if (hdr_qd != 16'd0) begin
                  nb = 1'b1;
                  nb_ph = PH_QNAME;
                end else begin
                  go_ans = 1'b1;
                end
              end
            end
            PH_QNAME, PH_ANAME: st_d = S_WALK;
            default: ;  // pull with no complete message: nothing
          endcase
        end
      end

      S_WALK: begin
        if (lr_q != 6'd0) begin
          if (CW'(chars_q) < CW'(NAME_CHARS)) begin
            st_d = S_CHR;
          end else begin
            // name full: skip rest of label
            off_d = off_q + OW'(lr_q);
            lr_d  = '0;
          end
        end else if (CW'(off_q) >= CW'(len_q) || step_q >= STEP_LIMIT) begin
          if (pt_q) off_d = res_q;
          st_d = S_REC;
        end else begin
          step_d = step_q + 8'd1;
          off_d  = off_q + OW'(1);
          st_d   = S_LAB;
        end
      end

      S_LAB: begin
        if (rdata == 8'd0) begin
          if (pt_q) off_d = res_q;
          st_d = S_REC;
        end else if (rdata[7:6] == LABEL_PTR) begin
          if (CW'(off_q) >= CW'(len_q)) begin
            out_d = '0; out_d.kind = K_EBADNAME; ov_d = 1'b1;
            ph_d = PH_DONE; st_d = S_IDLE;
          end else begin
            plo_d = rdata[5:0];
            off_d = off_q + OW'(1);
            st_d  = S_PTR;
          end
        end else if (rdata[7:6] != 2'b00 ||
                     CW'(off_q) + CW'(rdata) > CW'(len_q)) begin
          out_d = '0; out_d.kind = K_EBADNAME; ov_d = 1'b1;
          ph_d = PH_DONE; st_d = S_IDLE;
        end else begin
          lr_d = rdata[5:0];
          if (chars_q != 8'd0 && CW'(chars_q) < CW'(NAME_CHARS)) begin
            out_d = '0; out_d.kind = K_CHAR; out_d.name_char = DOT_CHAR;
            ov_d = 1'b1; chars_d = chars_q + 8'd1; st_d = S_IDLE;
          end else begin
            st_d = S_WALK;
          end
        end
      end

      S_PTR: begin
        if (!pt_q) begin
          res_d = off_q;
          pt_d  = 1'b1;
        end
        if (CW'(ptr) >= CW'(len_q)) begin
          out_d = '0; out_d.kind = K_EBADNAME; ov_d = 1'b1;
          ph_d = PH_DONE; st_d = S_IDLE;
        end else begin
          off_d = OW'(ptr);
          st_d  = S_WALK;
        end
      end

      S_CHR: begin
        out_d = '0; out_d.kind = K_CHAR; out_d.name_char = rdata;
        ov_d = 1'b1;
        off_d = off_q + OW'(1);
        lr_d = lr_q - 6'd1;
        chars_d = chars_q + 8'd1;
        st_d = S_IDLE;
      end

      S_REC: begin
        fip_d = 1'b0;
        if (ph_q == PH_QNAME) begin
          if (CW'(off_q) + CW'(QUES_FIX_BYTES) > CW'(len_q)) begin
            out_d = '0; out_d.kind = K_ESHORTQ; ov_d = 1'b1;
            ph_d = PH_DONE; st_d = S_IDLE;
          end else begin
            cnt_d = QUES_FIX_BYTES; st_d = S_FREQ;
          end
        end else begin
          if (CW'(off_q) + CW'(ANS_FIX_BYTES) > CW'(len_q)) begin
            out_d = '0; out_d.kind = K_ESHORTA; ov_d = 1'b1;
            ph_d = PH_DONE; st_d = S_IDLE;
          end else begin
            cnt_d = ANS_FIX_BYTES; st_d = S_FREQ;
          end
        end
      end

      S_FREQ: begin
        off_d = off_q + OW'(1);
        cnt_d = cnt_q - 4'd1;
        st_d  = S_FDAT;
      end

      S_FDAT: begin
        if (fip_q) ip_d = {ip_q[23:0], rdata};
        else acc_d = {acc_q[71:0], rdata};
        if (cnt_q != 4'd0) st_d = S_FREQ;
        else if (!fip_q && ph_q == PH_ANAME) st_d = S_ACHK;
        else st_d = S_FIN;
      end

      S_ACHK: begin
        ip_d = '0;
        rdoff_d = off_q;
        if (CW'(off_q) + CW'(acc_q[15:0]) > CW'(len_q)) begin
          out_d = '0; out_d.kind = K_ESHORTRD; ov_d = 1'b1;
          ph_d = PH_DONE; st_d = S_IDLE;
        end else if (acc_q[79:64] == TYPE_A && acc_q[15:0] == IPV4_LEN) begin
          fip_d = 1'b1; cnt_d = 4'd4; st_d = S_FREQ;
        end else begin
          st_d = S_FIN;
        end
      end

      S_FIN: begin
        out_d = '0; ov_d = 1'b1; st_d = S_IDLE;
        rec_d = rec_inc;
        if (ph_q == PH_QNAME) begin
          out_d.kind     = K_QUES;
          out_d.rr_type  = acc_q[31:16];
          out_d.rr_class = acc_q[15:0];
          if (rec_inc < hdr_qd) begin
            nb = 1'b1; nb_ph = PH_QNAME;
          end else begin
            go_ans = 1'b1;
          end
        end else begin
          out_d.kind         = K_ANS;
          out_d.rr_type      = acc_q[79:64];
          out_d.rr_class     = acc_q[63:48];
          out_d.ttl          = acc_q[47:16];
          out_d.rdata_len    = acc_q[15:0];
          out_d.rdata_offset = 14'(rdoff_q);
          out_d.ipv4_addr    = ip_q;
          off_d = OW'(CW'(rdoff_q) + CW'(acc_q[15:0]));
          if (rec_inc < hdr_an && rec_inc < 16'(maxa_q)) begin
            nb = 1'b1; nb_ph = PH_ANAME;
          end else begin
            ph_d = PH_DONE;
          end
        end
      end

      default: st_d = S_IDLE;
    endcase

    if (go_ans) begin
      rec_d = '0;
      if (hdr_an != 16'd0 && maxa_q != 4'd0) begin
        nb = 1'b1; nb_ph = PH_ANAME;
      end else begin
        ph_d = PH_DONE;
      end
    end
    if (nb) begin
      ph_d = nb_ph; pt_d = 1'b0; step_d = '0; chars_d = '0; lr_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;  ph_q <= PH_IDLE;  len_q <= '0;  off_q <= '0;
      res_q <= '0;  pt_q <= 1'b0;  step_q <= '0;  chars_q <= '0;
      lr_q <= '0;  rec_q <= '0;  maxa_q <= MAX_ANSWERS_RST;  ov_q <= 1'b0;
      fip_q <= 1'b0;  cnt_q <= '0;
    end else begin
      st_q <= st_d;  ph_q <= ph_d;  len_q <= len_d;  off_q <= off_d;
      res_q <= res_d;  pt_q <= pt_d;  step_q <= step_d;  chars_q <= chars_d;
      lr_q <= lr_d;  rec_q <= rec_d;  maxa_q <= maxa_d;  ov_q <= ov_d;
      fip_q <= fip_d;  cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rdoff_q <= rdoff_d;  plo_q <= plo_d;  hdr_q <= hdr_d;
    acc_q <= acc_d;  ip_q <= ip_d;  out_q <= out_d;
  end

endmodule

// ===== src/dmp_ram.sv =====
module dmp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/dmp_checker.sv =====
module dmp_checker import dmp_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input in_req_t  in_req_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input out_req_t out_req_o
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))
    else $error("result dropped while stalled");

  // nothing new is taken while a result waits
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request taken while result pending");

  // a load never yields a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !in_req_i.func |=> !out_valid_o)
    else $error("result after a load");

  // a result leaves the block free once taken
  a_free_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o && !in_stall_o)
    else $error("block not free after result taken");

endmodule

bind dns_message_parser_core dmp_checker u_dmp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_req_o   (out_req_o)
);
